// ===== rtl/core/ssde_pkg.sv =====
// Shared types and constants for the sorted set difference event block.
// No dependencies.
package ssde_pkg;

    localparam int MaxVisitorsDefault = 16;
    localparam int IdW = 16;
    localparam int GenW = 16;
    localparam int DropW = 8;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        KIND_BEGIN = 2'd0,
        KIND_END   = 2'd1,
        KIND_NONE  = 2'd2
    } t_kind;

    typedef struct packed {
        logic            action;
        logic [IdW-1:0]  shape_id;
        logic [GenW-1:0] generation;
        logic            muted;
    } t_in_item;

    typedef struct packed {
        t_kind            kind;
        logic [IdW-1:0]   visitor_id;
        logic [GenW-1:0]  visitor_generation;
        logic             last;
        logic [DropW-1:0] dropped;
    } t_out_item;

    // Close command from the front to the back.
    typedef struct packed {
        logic             muted;
        logic [DropW-1:0] dropped;
    } t_close_cmd;

endpackage

// ===== rtl/core/ssde_front.sv =====
// Front part: holds the current set, sorted by id, built by insertion.
// Depends on ssde_pkg.
module ssde_front import ssde_pkg::*; #(
    parameter int MAX_VISITORS = MaxVisitorsDefault,
    parameter int CntW = $clog2(MAX_VISITORS + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_in_item                 i_item,
    // close command out
    output logic                     o_cmd_valid,
    input  logic                     i_cmd_ready,
    output t_close_cmd               o_cmd,
    // snapshot handed over at close
    output logic [IdW+GenW-1:0]      o_set [MAX_VISITORS],
    output logic [CntW-1:0]          o_count
);

    logic [IdW+GenW-1:0] r_set [MAX_VISITORS];
    logic [CntW-1:0]     r_count, r_raw;
    logic [DropW-1:0]    r_drop;
    logic                hit;
    logic [MAX_VISITORS-1:0] gt;
    logic                take;

    assign o_ready     = i_item.action ? i_cmd_ready : 1'b1;
    assign take        = i_valid && o_ready;
    assign o_cmd_valid = i_valid && i_item.action;
    assign o_cmd.muted = i_item.muted;
    assign o_cmd.dropped = r_drop;
    assign o_count     = r_count;

    // compare the new id against every held entry in parallel
    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < MAX_VISITORS; i++) begin
            gt[i] = (CntW'(i) < r_count) && (r_set[i][IdW+GenW-1:GenW] > i_item.shape_id);
            if ((CntW'(i) < r_count) && (r_set[i][IdW+GenW-1:GenW] == i_item.shape_id))
                hit = 1'b1;
        end
    end

    // insert with shift: entries above the new id move up by one
    always_ff @(posedge i_clk) begin
        if (take && !i_item.action && r_raw < CntW'(MAX_VISITORS) && !hit
            && r_count < CntW'(MAX_VISITORS)) begin
            for (int i = 0; i < MAX_VISITORS; i++) begin
                if (gt[i]) begin
                    if (i + 1 < MAX_VISITORS) r_set[i+1] <= r_set[i];
                    if (i == 0 || !gt[(i == 0) ? 0 : i-1])
                        r_set[i] <= {i_item.shape_id, i_item.generation};
                end else if (CntW'(i) == r_count && gt == '0) begin
                    r_set[i] <= {i_item.shape_id, i_item.generation};
                end
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_VISITORS; g++) begin : g_out
            assign o_set[g] = r_set[g];
        end
    endgenerate

    // counters; clear on close
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_raw   <= '0;
            r_drop  <= '0;
        end else if (take && i_item.action) begin
            r_count <= '0;
            r_raw   <= '0;
            r_drop  <= '0;
        end else if (take) begin
            if (r_raw >= CntW'(MAX_VISITORS)) begin
                if (r_drop != '1) r_drop <= r_drop + 1'b1;
            end else begin
                r_raw <= r_raw + 1'b1;
                if (!hit && r_count < CntW'(MAX_VISITORS)) r_count <= r_count + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/ssde_back.sv =====
// Back part: merge-joins the snapshot against the previous set, emits events.
// Depends on ssde_pkg.
module ssde_back import ssde_pkg::*; #(
    parameter int MAX_VISITORS = MaxVisitorsDefault,
    parameter int CntW = $clog2(MAX_VISITORS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  t_close_cmd          i_cmd,
    input  logic [IdW+GenW-1:0] i_set [MAX_VISITORS],
    input  logic [CntW-1:0]     i_count,
    output logic                o_valid,
    input  logic                i_ready,
    output t_out_item           o_item
);
    localparam int IdxW = $clog2(MAX_VISITORS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state              r_state;
    logic [IdW+GenW-1:0] r_prev [MAX_VISITORS];
    logic [IdW+GenW-1:0] r_cur  [MAX_VISITORS];
    logic [CntW-1:0]     r_np, r_nc, r_i1, r_i2;
    logic [DropW-1:0]    r_drop;
    logic                r_half, r_hv;
    logic                r_ov;
    t_out_item           r_out;
    t_out_item           r_hold;

    logic [IdW+GenW-1:0] a, b;
    logic has_a, has_b, take_a, take_b, emit, two, done, step, load, pop;
    t_out_item nxt, n_out;

    assign o_cmd_ready = (r_state == ST_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_item  = r_out;

    always_comb begin
        a = r_prev[r_i1[IdxW-1:0]];
        b = r_cur[r_i2[IdxW-1:0]];
        has_a = r_i1 < r_np;
        has_b = r_i2 < r_nc;
        take_a = 1'b0; take_b = 1'b0; emit = 1'b1; two = 1'b0;
        nxt = '0;
        nxt.dropped = r_drop;
        // choose next event
        priority if (has_a && has_b && a[IdW+GenW-1:GenW] == b[IdW+GenW-1:GenW]) begin
            if (a[GenW-1:0] == b[GenW-1:0]) begin
                emit = 1'b0; take_a = 1'b1; take_b = 1'b1;
            end else if ((a[GenW-1:0] < b[GenW-1:0]) != r_half) begin
                nxt.kind = KIND_END; {nxt.visitor_id, nxt.visitor_generation} = a;
                two = 1'b1;
            end else begin
                nxt.kind = KIND_BEGIN; {nxt.visitor_id, nxt.visitor_generation} = b;
                two = 1'b1;
            end
            if (two && r_half) begin take_a = 1'b1; take_b = 1'b1; end
        end else if (has_a && (!has_b || a[IdW+GenW-1:GenW] < b[IdW+GenW-1:GenW])) begin
            nxt.kind = KIND_END; {nxt.visitor_id, nxt.visitor_generation} = a; take_a = 1'b1;
        end else if (has_b) begin
            nxt.kind = KIND_BEGIN; {nxt.visitor_id, nxt.visitor_generation} = b; take_b = 1'b1;
        end else begin
            emit = 1'b0;
        end
        done = !has_a && !has_b;

        // hold each event back in r_hold so the final one can carry last
        step = (r_state == ST_RUN) && (!r_ov || i_ready);
        load = step && (done || (emit && r_hv));
        pop  = r_ov && i_ready;
        n_out = r_hold;
        if (done) begin
            if (!r_hv) begin
                n_out = '0;
                n_out.kind = KIND_NONE;
                n_out.dropped = r_drop;
            end
            n_out.last = 1'b1;
        end
    end

    // step the merge once per cycle while the output slot is free or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_np <= '0;
            r_ov <= 1'b0;
            r_hv <= 1'b0;
        end else begin
            r_ov <= load || (r_ov && !pop);
            if (load) r_out <= n_out;
            unique case (r_state)
                ST_IDLE: if (i_cmd_valid && !r_ov) begin
                    r_state <= ST_RUN;
                    r_nc <= i_cmd.muted ? '0 : i_count;
                    r_drop <= i_cmd.dropped;
                    r_cur <= i_set;
                    r_i1 <= '0; r_i2 <= '0; r_half <= 1'b0; r_hv <= 1'b0;
                end
                ST_RUN: if (step) begin
                    if (done) begin
                        r_state <= ST_IDLE;
                        r_prev <= r_cur; r_np <= r_nc;
                        r_hv <= 1'b0;
                    end else begin
                        if (emit) begin r_hold <= nxt; r_hv <= 1'b1; end
                        if (two) r_half <= !r_half;
                        if (take_a) r_i1 <= r_i1 + 1'b1;
                        if (take_b) r_i2 <= r_i2 + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/sorted_set_diff_events_core.sv =====
// Sorted set difference event block, top level.
// Usage: i_in_valid/o_in_ready carry t_in_item; o_out_valid/i_out_ready carry
// t_out_item. An add transfer is taken every cycle and inserted in sorted
// order by a parallel compare-and-shift in the front part. A close transfer
// hands the set to the back part, which walks the previous and current sets
// one step per cycle (an event, or an unchanged pair skipped). Each event is
// held back in a hold register, so a result leaves once the next event is
// found or at the finishing step, which sets last on the final one.
// While the back part is busy, a close waits; adds proceed. Each close yields
// at least one result. A close with no change gives one kind NONE result.
// The walk pauses while the output register holds a result the receiver has
// not taken; the output register holds the result until transferred.
// Synchronous active-low reset empties both sets and clears the add and drop counters.
// Depends on ssde_pkg.
module sorted_set_diff_events_core import ssde_pkg::*; #(
    parameter int MAX_VISITORS = MaxVisitorsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);
    localparam int CntW = $clog2(MAX_VISITORS + 1);

    logic cmd_valid, cmd_ready;
    t_close_cmd cmd;
    logic [IdW+GenW-1:0] set [MAX_VISITORS];
    logic [CntW-1:0] cnt;

    ssde_front #(.MAX_VISITORS(MAX_VISITORS), .CntW(CntW)) u_front (
        .i_clk, .i_rst_n, .i_valid(i_in_valid), .o_ready(o_in_ready),
        .i_item(i_in_item), .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready),
        .o_cmd(cmd), .o_set(set), .o_count(cnt));

    ssde_back #(.MAX_VISITORS(MAX_VISITORS), .CntW(CntW)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready),
        .i_cmd(cmd), .i_set(set), .i_count(cnt), .o_valid(o_out_valid),
        .i_ready(i_out_ready), .o_item(o_out_item));
endmodule

// ===== rtl/core/ssde_checker.sv =====
// Port checker for the sorted set difference event block.
// Depends on ssde_pkg.
module ssde_checker import ssde_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output dropped while stalled");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.kind != 2'd3)
        else $error("bad kind");
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_NONE |-> o_out_item.last)
        else $error("no-change result not last");
endmodule

bind sorted_set_diff_events_core ssde_checker u_chk (.*);

// ===== tb/tb_sorted_set_diff_events_core.sv =====
// Self-checking testbench for sorted_set_diff_events_core: drives add/close
// transfers, predicts begin/end events with a scoreboard class and compares.
// Depends on ssde_pkg and the RTL top level.
module tb_sorted_set_diff_events_core;
    import ssde_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Cap = MaxVisitorsDefault;
    localparam int StallLimit = 5000;

    // Event predictor and store of expected events
    class visitor_event_board;
        logic [31:0] prev_pairs[Cap];
        logic [31:0] cur_pairs[Cap];
        int prev_n;
        int cur_n;
        int adds_taken;
        logic [7:0] drops;
        t_out_item pending_events[$];
        int errors;
        int events_checked;
        int closes_seen;

        function new();
            prev_n = 0;
            cur_n = 0;
            adds_taken = 0;
            drops = '0;
            errors = 0;
            events_checked = 0;
            closes_seen = 0;
        endfunction

        function void push_event(t_kind k, logic [31:0] pair);
            t_out_item e;
            e.kind = k;
            e.visitor_id = pair[31:16];
            e.visitor_generation = pair[15:0];
            e.last = 1'b0;
            e.dropped = drops;
            pending_events.push_back(e);
        endfunction

        // Note an accepted input transfer
        function void note_input(t_in_item it);
            int pos;
            int n1;
            int n2;
            int i1;
            int i2;
            int before_n;
            bit dup;
            if (!it.action) begin
                if (adds_taken >= Cap) begin
                    if (drops != 8'hFF) drops++;
                    return;
                end
                adds_taken++;
                pos = cur_n;
                dup = 0;
                for (int i = 0; i < cur_n; i++) begin
                    if (cur_pairs[i][31:16] == it.shape_id) begin
                        dup = 1;
                        break;
                    end
                    if (cur_pairs[i][31:16] > it.shape_id) begin
                        pos = i;
                        break;
                    end
                end
                if (dup || cur_n >= Cap) return;
                for (int i = cur_n; i > pos; i--) cur_pairs[i] = cur_pairs[i-1];
                cur_pairs[pos] = {it.shape_id, it.generation};
                cur_n++;
                return;
            end
            // Merge-join previous against current
            closes_seen++;
            before_n = pending_events.size();
            n1 = prev_n;
            n2 = it.muted ? 0 : cur_n;
            i1 = 0;
            i2 = 0;
            while (i1 < n1 || i2 < n2) begin
                if (i1 < n1 && i2 < n2) begin
                    if (prev_pairs[i1][31:16] == cur_pairs[i2][31:16]) begin
                        if (prev_pairs[i1][15:0] < cur_pairs[i2][15:0]) begin
                            push_event(KIND_END, prev_pairs[i1]);
                            push_event(KIND_BEGIN, cur_pairs[i2]);
                        end else if (prev_pairs[i1][15:0] > cur_pairs[i2][15:0]) begin
                            push_event(KIND_BEGIN, cur_pairs[i2]);
                            push_event(KIND_END, prev_pairs[i1]);
                        end
                        i1++;
                        i2++;
                    end else if (prev_pairs[i1][31:16] < cur_pairs[i2][31:16]) begin
                        push_event(KIND_END, prev_pairs[i1]);
                        i1++;
                    end else begin
                        push_event(KIND_BEGIN, cur_pairs[i2]);
                        i2++;
                    end
                end else if (i1 < n1) begin
                    push_event(KIND_END, prev_pairs[i1]);
                    i1++;
                end else begin
                    push_event(KIND_BEGIN, cur_pairs[i2]);
                    i2++;
                end
            end
            if (pending_events.size() == before_n) push_event(KIND_NONE, '0);
            pending_events[pending_events.size()-1].last = 1'b1;
            for (int i = 0; i < n2; i++) prev_pairs[i] = cur_pairs[i];
            prev_n = n2;
            cur_n = 0;
            adds_taken = 0;
            drops = '0;
        endfunction

        // Check one accepted result against the oldest expectation
        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result kind=%0d id=%0h gen=%0h last=%0b drop=%0d",
                         $time, got.kind, got.visitor_id, got.visitor_generation,
                         got.last, got.dropped);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            events_checked++;
            if (got.kind !== want.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.visitor_id !== want.visitor_id) begin
                $display("%0t: visitor_id expected %0h actual %0h", $time,
                         want.visitor_id, got.visitor_id);
                errors++;
            end
            if (got.visitor_generation !== want.visitor_generation) begin
                $display("%0t: visitor_generation expected %0h actual %0h", $time,
                         want.visitor_generation, got.visitor_generation);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
                errors++;
            end
            if (got.dropped !== want.dropped) begin
                $display("%0t: dropped expected %0d actual %0d", $time,
                         want.dropped, got.dropped);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    visitor_event_board board;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    int items_sent;

    sorted_set_diff_events_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Monitor transfers on both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) board.note_input(i_in_item);
            if (o_out_valid && i_out_ready) board.check_result(o_out_item);
        end
    end

    // Receiver: stall at random
    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: count cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("%0t: watchdog expired", $time);
            $display("sorted_set_diff_events_core regression: fail");
            $finish;
        end
    end

    // Send one item; hold valid until the transfer, then leave it to the next caller
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_add(logic [15:0] id, logic [15:0] gen);
        t_in_item it;
        it.action = 1'b0;
        it.shape_id = id;
        it.generation = gen;
        it.muted = 1'($urandom_range(1));
        send_item(it);
    endtask

    task automatic send_close(logic mute);
        t_in_item it;
        it.action = 1'b1;
        it.shape_id = 16'($urandom);
        it.generation = 16'($urandom);
        it.muted = mute;
        send_item(it);
    endtask

    // One random step, drawn mostly from a small id pool so ids recur across steps
    task automatic random_step();
        int n;
        int pool;
        n = ($urandom_range(9) == 0) ? $urandom_range(Cap + 6, Cap) : $urandom_range(6);
        pool = ($urandom_range(3) == 0) ? 65536 : 24;
        for (int i = 0; i < n; i++) begin
            if (pool == 24)
                send_add(16'($urandom_range(23)), 16'($urandom_range(3)));
            else
                send_add(16'($urandom), 16'($urandom));
        end
        send_close($urandom_range(9) == 0);
    endtask

    // Drop valid and wait for every expected event
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending_events.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        board = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty close, extremes, duplicates, generation swaps
        send_close(1'b0);
        send_add(16'hFFFF, 16'hFFFF);
        send_add(16'h0000, 16'h0000);
        send_add(16'h0000, 16'h1234);
        send_add(16'h8000, 16'h0001);
        send_close(1'b0);
        send_add(16'hFFFF, 16'h0000);
        send_add(16'h0000, 16'hFFFF);
        send_add(16'h8000, 16'h0001);
        send_add(16'h5555, 16'hAAAA);
        send_close(1'b0);
        send_close(1'b0);
        send_add(16'hAAAA, 16'h5555);
        send_close(1'b1);
        // Overflow: capacity plus a few, with duplicates
        for (int i = 0; i < Cap + 4; i++) send_add(16'(i % 12), 16'(i));
        send_close(1'b0);

        // Sender pauses until every expected event has arrived
        wait_drained();
        repeat (40) @(negedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 68 : 0;
            recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 20 : 0;
            while (items_sent < 35 + 45 * (phase + 1)) random_step();
        end
        // Saturate the drop counter once
        for (int i = 0; i < 280; i++) send_add(16'($urandom), 16'($urandom));
        send_close(1'b0);

        wait_drained();
        repeat (2 * Cap + 20) @(negedge i_clk);
        $display("Sent %0d items over %0d closes; checked %0d events.",
                 items_sent, board.closes_seen, board.events_checked);
        if (board.errors == 0 && board.pending_events.size() == 0)
            $display("sorted_set_diff_events_core regression: pass");
        else
            $display("sorted_set_diff_events_core regression: fail");
        $finish;
    end
endmodule
